### hw/rtl/wideband_gammatone_filter_macros.svh
// Assertion macros for the wideband gammatone filter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef WIDEBAND_GAMMATONE_FILTER_MACROS_SVH
`define WIDEBAND_GAMMATONE_FILTER_MACROS_SVH
`ifndef SYNTH
`define WGF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WGF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WGF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define WGF_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/wgf_pkg.sv
// Package for the wideband gammatone filter: state encoding, register indexes, widths,
// the fixed sine polynomial coefficients and a 32-bit saturation helper. Depends on nothing.
package wgf_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_COEF,
        ST_MIX,
        ST_MIXSAT,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_OUT1,
        ST_OUT2,
        ST_HOLD
    } state_t;

    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_LOOP_GAIN = 2'd1;
    localparam logic [1:0] REG_ORDER     = 2'd2;
    localparam logic [1:0] REG_TWO_OVER  = 2'd3;

    localparam int SAMPLE_W = 24;
    localparam int TAU_W    = 32;
    localparam int OUT_W    = 32;
    localparam int STAGE_W  = 32;

    localparam longint SIN_P0 = 1686629713;
    localparam longint SIN_P1 = -693598668;
    localparam longint SIN_P2 = 85569305;
    localparam longint SIN_P3 = -5026988;
    localparam longint SIN_P4 = 172272;
    localparam longint SIN_P5 = -3864;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Quarter-wave sine in Q1.30; evaluated only at elaboration for tables.
    function automatic longint quarter_sine(input longint u);
        longint s;
        longint acc;
        s = (u * u) >>> 30;
        acc = SIN_P5;
        acc = SIN_P4 + ((acc * s) >>> 30);
        acc = SIN_P3 + ((acc * s) >>> 30);
        acc = SIN_P2 + ((acc * s) >>> 30);
        acc = SIN_P1 + ((acc * s) >>> 30);
        acc = SIN_P0 + ((acc * s) >>> 30);
        acc = (acc * u) >>> 30;
        if (acc > (64'sd1 << 30)) begin
            acc = 64'sd1 << 30;
        end
        if (acc < 0) begin
            acc = 0;
        end
        return acc;
    endfunction

endpackage

### hw/rtl/wgf_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module wgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/wgf_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on nothing.
module wgf_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0]  q_reg, q_next;
    logic [64:0]  r_reg, r_next;
    logic [63:0]  d_reg, d_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [64:0]  trial;
    logic [65:0]  diff;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[63:0], q_reg[63]};
        diff      = {1'b0, trial} - {2'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[65]) begin
                r_next = diff[64:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

### hw/rtl/wideband_gammatone_filter.sv
// Wideband gammatone filter (needs wgf_pkg, wgf_ram, wgf_divider and the macro header).
// Sequence per request: two 64-step divider runs (c1, then c2), then each stage passes
// through ST_RD, ST_MUL and ST_ADD using the RAMs, then ST_OUT1, ST_OUT2 and ST_HOLD.
// No new request is taken until the previous one is through; a waiting result holds input.
// Reset (aresetn low, synchronous): registers to defaults, phase zero, then a clearing
// pass over the MAX_ORDER+1 entries of the stage RAMs during which no request is taken.
`include "wideband_gammatone_filter_macros.svh"
module wideband_gammatone_filter #(
    parameter int MAX_ORDER       = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [23:0] sample_in, [55:24] time_constant, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sample_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int DEPTH  = MAX_ORDER + 1;
    localparam int AW     = $clog2(DEPTH + 1);
    localparam int TSIZE  = 1 << SINE_TABLE_BITS;
    localparam int QUART  = TSIZE / 4;
    localparam int RAW    = $clog2(DEPTH);

    // Sine table built at elaboration from the quarter-wave polynomial.
    function automatic logic signed [31:0] sine_entry(input int k);
        longint u;
        longint v;
        int     quad;
        quad = k / QUART;
        u = longint'(k % QUART) <<< (32 - SINE_TABLE_BITS);
        if (quad % 2 == 1) begin
            u = (64'sd1 <<< 30) - u;
        end
        v = wgf_pkg::quarter_sine(u);
        if (quad >= 2) begin
            v = -v;
        end
        return 32'(v);
    endfunction

    logic signed [31:0] sine_rom [TSIZE];
    for (genvar g = 0; g < TSIZE; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // Configuration registers.
    logic [31:0] phase_inc_reg;
    logic [23:0] loop_gain_reg;
    logic [3:0]  order_reg;
    logic [21:0] two_over_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= '0;
            loop_gain_reg <= 24'd65536;
            order_reg     <= 4'd3;
            two_over_reg  <= 22'd200000;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                wgf_pkg::REG_PHASE_INC: phase_inc_reg <= pwdata;
                wgf_pkg::REG_LOOP_GAIN: loop_gain_reg <= pwdata[23:0];
                wgf_pkg::REG_ORDER:     order_reg     <= pwdata[3:0];
                wgf_pkg::REG_TWO_OVER:  two_over_reg  <= pwdata[21:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wgf_pkg::REG_PHASE_INC: prdata = phase_inc_reg;
            wgf_pkg::REG_LOOP_GAIN: prdata = {8'd0, loop_gain_reg};
            wgf_pkg::REG_ORDER:     prdata = {28'd0, order_reg};
            wgf_pkg::REG_TWO_OVER:  prdata = {10'd0, two_over_reg};
            default:                prdata = '0;
        endcase
    end

    // Effective order clamped to 1..MAX_ORDER.
    logic [AW-1:0] order_eff;
    always_comb begin
        if (order_reg == 4'd0) begin
            order_eff = AW'(1);
        end else if (32'(order_reg) > MAX_ORDER) begin
            order_eff = AW'(MAX_ORDER);
        end else begin
            order_eff = AW'(order_reg);
        end
    end

    // Request datapath state.
    wgf_pkg::state_t state_reg, state_next;
    logic signed [23:0] x_reg;
    logic [31:0]  phase_reg;
    logic signed [31:0] cs_reg, sn_reg;
    logic [63:0]  den_reg;
    logic         div_sel_reg;       // 0: c1 divide, 1: c2 divide
    logic signed [31:0] c1_reg;      // Q1.30
    logic signed [31:0] c2_reg;      // Q8.16, fits 32 bits signed
    logic signed [63:0] pr_reg, pi_reg, qr_reg, qi_reg;
    logic signed [31:0] fr_reg, fi_reg;   // new value of previous stage
    logic [AW-1:0] j_reg;
    logic signed [31:0] out_reg;
    logic         mvalid_reg;
    logic [RAW-1:0] clr_reg;
    logic         clr_busy_reg;

    // Stage memories.
    logic           ram_we;
    logic [RAW-1:0] ram_waddr, ram_raddr;
    logic [31:0]    re_wdata, im_wdata, re_rdata, im_rdata;

    wgf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_re (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(re_wdata),
        .raddr(ram_raddr), .rdata(re_rdata)
    );
    wgf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_im (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(im_wdata),
        .raddr(ram_raddr), .rdata(im_rdata)
    );

    // Denominator of both divides; the first divide starts on the accepting edge,
    // so it takes the freshly computed value rather than the register.
    logic [63:0] den_calc;
    logic [63:0] div_den;
    assign den_calc = 64'(s_tdata[55:24]) * 64'(two_over_reg) + (64'd1 << 32);
    assign div_den  = (state_reg == wgf_pkg::ST_IDLE) ? den_calc : den_reg;

    // Shared divider.
    logic        div_start, div_done;
    logic [63:0] div_num, div_q;
    wgf_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_num),
        .divisor(div_den), .done(div_done), .quotient(div_q)
    );

    logic accept;
    assign s_tready = (state_reg == wgf_pkg::ST_IDLE) && !clr_busy_reg && !mvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [31:0] phase_new;
    assign phase_new = phase_reg + phase_inc_reg;
    assign idx = phase_new[31 -: SINE_TABLE_BITS];

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wgf_pkg::ST_IDLE:   if (accept) state_next = wgf_pkg::ST_DIV;
            wgf_pkg::ST_DIV:    if (div_done) state_next = div_sel_reg ? wgf_pkg::ST_COEF
                                                                   : wgf_pkg::ST_DIV;
            wgf_pkg::ST_COEF:   state_next = wgf_pkg::ST_MIX;
            wgf_pkg::ST_MIX:    state_next = wgf_pkg::ST_MIXSAT;
            wgf_pkg::ST_MIXSAT: state_next = wgf_pkg::ST_RD;
            wgf_pkg::ST_RD:     state_next = wgf_pkg::ST_MUL;
            wgf_pkg::ST_MUL:    state_next = wgf_pkg::ST_ADD;
            wgf_pkg::ST_ADD:    state_next = (j_reg == order_eff) ? wgf_pkg::ST_OUT1
                                                                  : wgf_pkg::ST_RD;
            wgf_pkg::ST_OUT1:   state_next = wgf_pkg::ST_OUT2;
            wgf_pkg::ST_OUT2:   state_next = wgf_pkg::ST_HOLD;
            wgf_pkg::ST_HOLD:   state_next = wgf_pkg::ST_IDLE;
            default:            state_next = wgf_pkg::ST_IDLE;
        endcase
    end

    // Output logic for memory and divider control.
    logic signed [32:0] sum_re, sum_im;
    assign sum_re = 33'(fr_reg) + 33'(signed'(re_rdata));
    assign sum_im = 33'(fi_reg) + 33'(signed'(im_rdata));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = RAW'(j_reg);
        re_wdata  = fr_reg;
        im_wdata  = fi_reg;
        ram_raddr = RAW'(j_reg);
        div_start = 1'b0;
        div_num   = 64'h8000_0000_0000_0000;
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            re_wdata  = '0;
            im_wdata  = '0;
        end
        unique case (state_reg)
            wgf_pkg::ST_COEF: begin
                div_start = 1'b0;
            end
            wgf_pkg::ST_DIV: begin
                if (div_done && !div_sel_reg) begin
                    div_start = 1'b1;
                    div_num   = {8'd0, loop_gain_reg, 32'd0};
                end
            end
            wgf_pkg::ST_RD: begin
                // previous stage's old value at j-1 is fetched first
                ram_raddr = RAW'(j_reg - AW'(1));
            end
            wgf_pkg::ST_MUL: begin
                ram_raddr = RAW'(j_reg);
            end
            wgf_pkg::ST_ADD: begin
                ram_we    = 1'b1;
                ram_waddr = RAW'(j_reg - AW'(1));
            end
            wgf_pkg::ST_OUT2: begin
                // The last stage's new value is in fr/fi from this cycle on.
                ram_we    = 1'b1;
                ram_waddr = RAW'(j_reg);
            end
            default: ;
        endcase
        if (state_reg == wgf_pkg::ST_IDLE && accept) begin
            div_start = 1'b1;
        end
    end

    // Sequencer data registers.
    logic signed [63:0] c1_term_re, c1_term_im;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wgf_pkg::ST_IDLE;
            mvalid_reg   <= 1'b0;
            phase_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_reg      <= '0;
            div_sel_reg  <= 1'b0;
            j_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (clr_busy_reg) begin
                clr_reg <= clr_reg + RAW'(1);
                if (32'(clr_reg) == DEPTH - 1) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (mvalid_reg && m_tready) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                wgf_pkg::ST_IDLE: begin
                    if (accept) begin
                        div_sel_reg <= 1'b0;
                        phase_reg   <= phase_new;
                    end
                end
                wgf_pkg::ST_DIV: begin
                    if (div_done) begin
                        div_sel_reg <= 1'b1;
                    end
                end
                wgf_pkg::ST_MIXSAT: j_reg <= AW'(1);
                wgf_pkg::ST_ADD: begin
                    if (j_reg != order_eff) begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                // The result register is loaded on this same edge.
                wgf_pkg::ST_HOLD: mvalid_reg <= 1'b1;
                default: ;
            endcase
        end
        // Payload registers.
        unique case (state_reg)
            wgf_pkg::ST_IDLE: begin
                x_reg   <= s_tdata[23:0];
                den_reg <= den_calc;
                sn_reg  <= sine_rom[idx];
                cs_reg  <= sine_rom[SINE_TABLE_BITS'(idx + SINE_TABLE_BITS'(QUART))];
            end
            wgf_pkg::ST_DIV: begin
                if (div_done && !div_sel_reg) begin
                    c1_reg <= 32'((64'sd1 <<< 30) - signed'(div_q));
                end
                if (div_done && div_sel_reg) begin
                    c2_reg <= 32'(div_q);
                end
            end
            wgf_pkg::ST_MIX: begin
                pr_reg <= 64'(x_reg) * 64'(cs_reg);
                pi_reg <= 64'(x_reg) * 64'(sn_reg);
            end
            wgf_pkg::ST_MIXSAT: begin
                fr_reg <= wgf_pkg::sat32(pr_reg >>> 26);
                fi_reg <= wgf_pkg::sat32(pi_reg >>> 26);
            end
            wgf_pkg::ST_MUL: begin
                // re_rdata holds old stage j-1; form c2 * (new + old).
                pr_reg <= 64'(c2_reg) * 64'(sum_re);
                pi_reg <= 64'(c2_reg) * 64'(sum_im);
            end
            wgf_pkg::ST_ADD: begin
                // re_rdata holds old stage j.
                qr_reg <= 64'(c1_reg) * 64'(signed'(re_rdata));
                qi_reg <= 64'(c1_reg) * 64'(signed'(im_rdata));
            end
            wgf_pkg::ST_OUT1: ;
            default: ;
        endcase
        if (state_reg == wgf_pkg::ST_ADD) begin
            // Stage j-1 new value written this cycle; compute stage j next.
        end
        if (state_reg == wgf_pkg::ST_RD && j_reg != AW'(1)) begin
            fr_reg <= wgf_pkg::sat32((pr_reg >>> 16) + (qr_reg >>> 30));
            fi_reg <= wgf_pkg::sat32((pi_reg >>> 16) + (qi_reg >>> 30));
        end
        if (state_reg == wgf_pkg::ST_OUT1) begin
            fr_reg <= wgf_pkg::sat32((pr_reg >>> 16) + (qr_reg >>> 30));
            fi_reg <= wgf_pkg::sat32((pi_reg >>> 16) + (qi_reg >>> 30));
        end
        if (state_reg == wgf_pkg::ST_OUT2) begin
            c1_term_re <= 64'(cs_reg) * 64'(fr_reg);
            c1_term_im <= 64'(sn_reg) * 64'(fi_reg);
        end
        if (state_reg == wgf_pkg::ST_HOLD) begin
            out_reg <= wgf_pkg::sat32((c1_term_re + c1_term_im) >>> 30);
        end
    end

    `WGF_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, clr_busy_reg, !s_tready)
    `WGF_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == wgf_pkg::ST_IDLE)
    `WGF_ASSERT_NXT(a_acc_div, aclk, aresetn, accept, state_reg == wgf_pkg::ST_DIV)
    `WGF_ASSERT_IMP(a_j_range, aclk, aresetn, state_reg == wgf_pkg::ST_ADD, j_reg <= order_eff)
endmodule
